>>> rtl/lbp_pkg.sv
package lbp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int SUM_WIDTH   = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME = 2'd1;

    localparam logic [CFG_WIDTH-1:0] PERIOD_RST  = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] ON_TIME_RST = 16'd500;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_ENABLE     = 3'd1,
        OP_ENABLE_PLS = 3'd2,
        OP_DISABLE    = 3'd3,
        OP_SET_MODE   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_BLINK  = 2'd0,
        MODE_STEADY = 2'd1,
        MODE_PULSE  = 2'd2,
        MODE_IDLE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] pulse_add;
        logic [1:0]  mode_select;
    } cmd_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] period_ms;
        logic [CFG_WIDTH-1:0] on_time_ms;
    } cfg_t;

    typedef struct packed {
        logic        led_lit;
        logic        enabled_now;
        logic [1:0]  mode_now;
        logic [15:0] pulses_pending;
    } status_t;

endpackage

>>> rtl/lbp_cfg_regs.sv
module lbp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [lbp_pkg::CFG_WIDTH-1:0]  wr_data,
    output lbp_pkg::cfg_t                  cfg
);
    import lbp_pkg::*;

    logic [CFG_WIDTH-1:0] period_reg;
    logic [CFG_WIDTH-1:0] on_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RST;
            on_time_reg <= ON_TIME_RST;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_PERIOD)
            begin
                period_reg <= wr_data;
            end
            if (wr_index == REG_ON_TIME)
            begin
                on_time_reg <= wr_data;
            end
        end
    end

    assign cfg.period_ms  = period_reg;
    assign cfg.on_time_ms = on_time_reg;

endmodule

>>> rtl/lbp_ctrl.sv
module lbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lbp_pkg::cmd_t     cmd,
    input  lbp_pkg::cfg_t     cfg,
    output lbp_pkg::status_t  cur,
    output lbp_pkg::status_t  nxt
);
    import lbp_pkg::*;

    logic                   enabled_reg,  enabled_next;
    mode_t                  mode_reg,     mode_next;
    logic                   lit_reg,      lit_next;
    logic [COUNT_WIDTH-1:0] target_reg,   target_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg,  elapsed_next;
    logic [COUNT_WIDTH-1:0] goal_reg,     goal_next;
    logic [COUNT_WIDTH-1:0] done_reg,     done_next;

    logic                   at_target;
    logic [CFG_WIDTH-1:0]   off_len;
    logic [SUM_WIDTH-1:0]   goal_sum;

    assign at_target = (target_reg == elapsed_reg);
    assign off_len   = (cfg.period_ms > cfg.on_time_ms) ?
                       (cfg.period_ms - cfg.on_time_ms) : '0;
    assign goal_sum  = SUM_WIDTH'(goal_reg) + SUM_WIDTH'(cmd.pulse_add);

    always_comb
    begin
        enabled_next = enabled_reg;
        mode_next    = mode_reg;
        lit_next     = lit_reg;
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        goal_next    = goal_reg;
        done_next    = done_reg;

        case (cmd.opcode)
            OP_TICK:
            begin
                if (!enabled_reg)
                begin
                    elapsed_next = '0;
                    lit_next     = 1'b0;
                end
                else if (mode_reg == MODE_BLINK || mode_reg == MODE_PULSE)
                begin
                    if (!at_target)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                    else
                    begin
                        elapsed_next = '0;
                        if (lit_reg)
                        begin
                            // lit phase ends here
                            target_next = COUNT_WIDTH'(off_len);
                            lit_next    = 1'b0;
                            if (mode_reg == MODE_PULSE)
                            begin
                                if (done_reg == goal_reg)
                                begin
                                    enabled_next = 1'b0;
                                    mode_next    = MODE_STEADY;
                                    done_next    = '0;
                                    goal_next    = '0;
                                end
                                else
                                begin
                                    done_next = done_reg + 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            target_next = COUNT_WIDTH'(cfg.on_time_ms);
                            lit_next    = 1'b1;
                        end
                    end
                end
                else if (mode_reg == MODE_STEADY)
                begin
                    lit_next = 1'b1;
                end
            end
            OP_ENABLE:
            begin
                enabled_next = 1'b1;
            end
            OP_ENABLE_PLS:
            begin
                enabled_next = 1'b1;
                mode_next    = MODE_PULSE;
                goal_next    = (goal_sum > SUM_WIDTH'(CNT_MAX)) ?
                               CNT_MAX : COUNT_WIDTH'(goal_sum);
            end
            OP_DISABLE:
            begin
                enabled_next = 1'b0;
            end
            OP_SET_MODE:
            begin
                mode_next = mode_t'(cmd.mode_select);
            end
            default:
            begin
                enabled_next = enabled_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            mode_reg    <= MODE_STEADY;
            lit_reg     <= 1'b0;
            target_reg  <= '0;
            elapsed_reg <= '0;
            goal_reg    <= '0;
            done_reg    <= '0;
        end
        else if (step)
        begin
            enabled_reg <= enabled_next;
            mode_reg    <= mode_next;
            lit_reg     <= lit_next;
            target_reg  <= target_next;
            elapsed_reg <= elapsed_next;
            goal_reg    <= goal_next;
            done_reg    <= done_next;
        end
    end

    assign cur.led_lit        = lit_reg;
    assign cur.enabled_now    = enabled_reg;
    assign cur.mode_now       = mode_reg;
    assign cur.pulses_pending = 16'(goal_reg);

    assign nxt.led_lit        = lit_next;
    assign nxt.enabled_now    = enabled_next;
    assign nxt.mode_now       = mode_next;
    assign nxt.pulses_pending = 16'(goal_next);

endmodule

>>> rtl/led_blink_pulse_controller.sv
// LED blink / pulse controller.
// Result path: an accepted command beat is held in the input register, then
// its state update is written into the result register, raising out_valid.
// Throughput: one command per cycle, limited only by out_ready.
// Reset (rst_n low, async): disabled, steady mode, LED dark, counters zero,
// period 1000 and on time 500 ticks.
module led_blink_pulse_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    opcode,
    input  logic [15:0]                   pulse_add,
    input  logic [1:0]                    mode_select,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          led_lit,
    output logic                          enabled_now,
    output logic [1:0]                    mode_now,
    output logic [15:0]                   pulses_pending,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbp_pkg::CFG_WIDTH-1:0] cfg_data
);
    import lbp_pkg::*;

    logic    in_valid_reg;
    cmd_t    cmd_reg;
    logic    out_valid_reg;
    status_t res_reg;
    logic    out_free;
    logic    proc;
    cfg_t    cfg;
    status_t st_cur;
    status_t st_nxt;

    assign out_free  = !out_valid_reg || out_ready;
    assign proc      = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    lbp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lbp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proc),
        .cmd   (cmd_reg),
        .cfg   (cfg),
        .cur   (st_cur),
        .nxt   (st_nxt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg.opcode      <= opcode;
            cmd_reg.pulse_add   <= pulse_add;
            cmd_reg.mode_select <= mode_select;
        end
        if (proc)
        begin
            res_reg <= st_nxt;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_lit        = res_reg.led_lit;
    assign enabled_now    = res_reg.enabled_now;
    assign mode_now       = res_reg.mode_now;
    assign pulses_pending = res_reg.pulses_pending;

    a_proc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> out_valid)
        else $error("processed beat did not produce a result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room to advance");

    a_dark_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && cmd_reg.opcode == OP_TICK && !st_cur.enabled_now)
        |=> (!led_lit && !enabled_now))
        else $error("tick while disabled left LED lit");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> (res_reg == st_cur))
        else $error("result differs from updated state");

endmodule
